// File: hw/rtl/qtsd_pkg.sv
// Shared types and character codes for the quoted token stream decoder.
package qtsd_pkg;

  typedef enum logic [2:0] {
    PH_START     = 3'd0,
    PH_BODY      = 3'd1,
    PH_ESC       = 3'd2,
    PH_TERM      = 3'd3,
    PH_TERM_LINE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    END_OPEN  = 2'd0,
    END_TOKEN = 2'd1,
    END_LINE  = 2'd2
  } end_kind_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;

  localparam int unsigned OUT_BITS  = 12;
  localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

  typedef struct packed {
    end_kind_t  end_kind;
    logic [7:0] out_byte;
    logic       emit;
    logic       consumed;
  } result_t;

endpackage

// File: hw/rtl/quoted_token_stream_decoder_unit.sv
// Top level of the quoted token stream decoder: input register, state and result register.
//
//   channel  dir  tdata                  tuser
//   s_       in   in_byte[7:0]           action
//   m_       out  consumed, emit,        -
//                 out_byte, end_kind
//
// One byte per cycle is sustained while m_tready stays high; a beat taken into the input
// register moves on to the result register when the decoder state advances.
// The decoder state advances when an item moves from the input register to the
// result register; rst returns it to the whitespace-skipping start phase.
// A stall on m_tready holds the result and, with the input register full, s_tready.
module quoted_token_stream_decoder_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // in_byte[7:0]
  input  logic                                s_tuser,  // action
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // consumed[0], emit[1], out_byte[9:2], end_kind[11:10], zero[15:12]
  output logic [8*qtsd_pkg::OUT_BYTES-1:0]    m_tdata
);

  logic              in_valid;
  logic              in_action;
  logic [7:0]        in_data;
  logic              advance;
  qtsd_pkg::phase_t  phase;
  qtsd_pkg::phase_t  phase_next;
  logic              in_quotes;
  logic              in_quotes_next;
  qtsd_pkg::result_t step_result;
  qtsd_pkg::result_t result;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  qtsd_step u_step (
    .phase          (phase),
    .in_quotes      (in_quotes),
    .action         (in_action),
    .in_byte        (in_data),
    .phase_next     (phase_next),
    .in_quotes_next (in_quotes_next),
    .result         (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      m_tvalid  <= 1'b0;
      phase     <= qtsd_pkg::PH_START;
      in_quotes <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid  <= 1'b1;
        phase     <= phase_next;
        in_quotes <= in_quotes_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_data   <= s_tdata;
    end
    if (advance) begin
      result <= step_result;
    end
  end

  assign m_tdata = {{(8*qtsd_pkg::OUT_BYTES-qtsd_pkg::OUT_BITS){1'b0}}, result};

endmodule

// File: hw/rtl/qtsd_step.sv
// Per-byte decode step: next decoder state and the result for one item.
module qtsd_step (
  input  qtsd_pkg::phase_t  phase,
  input  logic              in_quotes,
  input  logic              action,
  input  logic [7:0]        in_byte,
  output qtsd_pkg::phase_t  phase_next,
  output logic              in_quotes_next,
  output qtsd_pkg::result_t result
);

  logic             ws;
  logic             first;
  qtsd_pkg::phase_t eff;
  logic [7:0]       esc_byte;

  assign ws = (in_byte == qtsd_pkg::CH_SPACE) ||
              ((in_byte >= qtsd_pkg::CH_TAB) && (in_byte <= qtsd_pkg::CH_CR));

  always_comb begin
    unique case (in_byte)
      qtsd_pkg::CH_LOW_T: esc_byte = qtsd_pkg::CH_TAB;
      qtsd_pkg::CH_LOW_N: esc_byte = qtsd_pkg::CH_NL;
      qtsd_pkg::CH_LOW_R: esc_byte = qtsd_pkg::CH_CR;
      default:            esc_byte = in_byte;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    in_quotes_next  = in_quotes;
    result.consumed = 1'b1;
    result.emit     = 1'b0;
    result.out_byte = 8'h00;
    first           = 1'b0;
    eff             = phase;

    // A non-whitespace byte in the start phase is handled as the first body byte.
    if (phase == qtsd_pkg::PH_START) begin
      if (!ws) begin
        eff   = qtsd_pkg::PH_BODY;
        first = 1'b1;
      end
      phase_next = eff;
    end

    if (action) begin
      phase_next      = qtsd_pkg::PH_START;
      in_quotes_next  = 1'b0;
      result.consumed = 1'b0;
    end else begin
      unique case (eff)
        qtsd_pkg::PH_START: begin
          // Leading whitespace is eaten silently.
        end
        qtsd_pkg::PH_BODY: begin
          priority if (in_quotes && in_byte == qtsd_pkg::CH_BSLASH) begin
            phase_next = qtsd_pkg::PH_ESC;
          end else if (!in_quotes && ws) begin
            phase_next = qtsd_pkg::PH_TERM;
          end else if (in_byte == qtsd_pkg::CH_QUOTE) begin
            if (first) begin
              in_quotes_next = 1'b1;
            end else begin
              phase_next = qtsd_pkg::PH_TERM;
            end
          end else if (in_byte == qtsd_pkg::CH_SEMI) begin
            phase_next = qtsd_pkg::PH_TERM_LINE;
          end else begin
            result.emit     = 1'b1;
            result.out_byte = in_byte;
          end
        end
        qtsd_pkg::PH_ESC: begin
          result.emit     = 1'b1;
          result.out_byte = esc_byte;
          phase_next      = qtsd_pkg::PH_BODY;
        end
        default: begin
          result.consumed = 1'b0;
        end
      endcase
    end

    unique case (phase_next)
      qtsd_pkg::PH_START, qtsd_pkg::PH_BODY, qtsd_pkg::PH_ESC:
        result.end_kind = qtsd_pkg::END_OPEN;
      qtsd_pkg::PH_TERM_LINE:
        result.end_kind = qtsd_pkg::END_LINE;
      default:
        result.end_kind = qtsd_pkg::END_TOKEN;
    endcase
  end

endmodule
